@@ rtl/core/resistor_ladder_key_decoder_core_assert.svh @@
// Assertion macros for the resistor ladder key decoder core.
`ifndef RESISTOR_LADDER_KEY_DECODER_CORE_ASSERT_SVH
`define RESISTOR_LADDER_KEY_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLKD_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLKD_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rlkd_pkg.sv @@
// Shared types and constants of the resistor ladder key decoder.
package rlkd_pkg;

  localparam int TIME_BITS       = 32;
  localparam int HALF_WIDTH_BITS = 8;
  localparam int INTERVAL_BITS   = 16;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [INTERVAL_BITS-1:0] DEBOUNCE_RESET = INTERVAL_BITS'(100);
  localparam logic [INTERVAL_BITS-1:0] HOLD_RESET     = INTERVAL_BITS'(200);

  // Register index offsets past the button level registers.
  localparam int REG_OFS_HALF_WIDTH = 0;
  localparam int REG_OFS_DEBOUNCE   = 1;
  localparam int REG_OFS_HOLD       = 2;
  localparam int REG_EXTRA_COUNT    = 3;

  typedef struct packed {
    logic latch;
    logic click;
    logic hold;
    logic rls;
  } btn_status_t;

endpackage

@@ rtl/core/rlkd_match.sv @@
// Window match of one sample against all button levels, lowest button wins.
module rlkd_match
  import rlkd_pkg::*;
#(
  parameter int NUM_BUTTONS = 5,
  parameter int SAMPLE_BITS = 10
) (
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic [SAMPLE_BITS-1:0]     level [NUM_BUTTONS],
  input  logic [HALF_WIDTH_BITS-1:0] half_width,
  output logic [NUM_BUTTONS-1:0]     hit
);

  localparam int WIDE_BITS = SAMPLE_BITS + 1;

  logic [NUM_BUTTONS-1:0] in_win;

  always_comb begin
    logic [WIDE_BITS-1:0] s_ext;
    logic [WIDE_BITS-1:0] w_ext;
    logic [WIDE_BITS-1:0] l_ext;
    s_ext = WIDE_BITS'(sample);
    w_ext = WIDE_BITS'(half_width);
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      l_ext = WIDE_BITS'(level[b]);
      in_win[b] = ((s_ext + w_ext) >= l_ext) && (s_ext <= (l_ext + w_ext));
    end
  end

  always_comb begin
    logic found;
    found = 1'b0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      hit[b] = in_win[b] && !found;
      found  = found || in_win[b];
    end
  end

endmodule

@@ rtl/core/rlkd_button.sv @@
// Per-button latch, timestamp and click, hold and release flags.
module rlkd_button
  import rlkd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     update,
  input  logic                     pressed,
  input  logic [TIME_BITS-1:0]     now_ms,
  input  logic [INTERVAL_BITS-1:0] debounce_ms,
  input  logic [INTERVAL_BITS-1:0] hold_repeat_ms,
  output btn_status_t              status
);

  logic [TIME_BITS-1:0] stamp;
  logic [TIME_BITS-1:0] stamp_next;
  btn_status_t          status_next;
  logic [TIME_BITS-1:0] elapsed;
  logic                 past_debounce;
  logic                 past_hold;

  assign elapsed       = now_ms - stamp;
  assign past_debounce = elapsed > TIME_BITS'(debounce_ms);
  assign past_hold     = elapsed > TIME_BITS'(hold_repeat_ms);

  always_comb begin
    status_next = status;
    stamp_next  = stamp;
    if (pressed && !status.latch && past_debounce) begin
      stamp_next  = now_ms;
      status_next = '{latch: 1'b1, click: 1'b1, hold: 1'b0, rls: 1'b0};
    end else if (pressed && status.latch && past_hold) begin
      stamp_next  = now_ms;
      status_next = '{latch: 1'b1, click: 1'b0, hold: 1'b1, rls: 1'b0};
    end else if (!pressed && !status.latch) begin
      status_next = '{latch: 1'b0, click: 1'b0, hold: 1'b0, rls: 1'b0};
    end else if (!pressed && status.latch && past_debounce) begin
      stamp_next  = now_ms;
      status_next = '{latch: 1'b0, click: 1'b0, hold: 1'b0, rls: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      stamp  <= '0;
    end else if (update) begin
      status <= status_next;
      stamp  <= stamp_next;
    end
  end

endmodule

@@ rtl/core/resistor_ladder_key_decoder_core.sv @@
// Top level of the resistor ladder key decoder core.
//
// Input channel: in_valid/in_ready carry one ADC sample and the millisecond
// time. Output channel: out_valid/out_ready carry the click, hold and release
// flags of every button plus the sample echo. Configuration channel:
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high,
// unknown indexes are ignored.
// An accepted item is registered in the input stage and moves on to the
// output when the output is empty or being taken by the receiver.
// Throughput is one item per cycle while out_ready stays high; the window
// match and button update into the button state registers are combinational.
// The button state registers double as the output register of flags and
// update only when the input stage item moves to the output.
// While the receiver stalls, the output holds, the input stage fills and then
// in_ready drops until out_ready returns.
// Reset clears both stages, all button latches, timestamps and flags, and
// loads the register reset values; there is no clearing pass.
module resistor_ladder_key_decoder_core
  import rlkd_pkg::*;
#(
  parameter int NUM_BUTTONS = 5,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [TIME_BITS-1:0]         now_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [NUM_BUTTONS-1:0]       click_flags,
  output logic [NUM_BUTTONS-1:0]       hold_flags,
  output logic [NUM_BUTTONS-1:0]       release_flags,
  output logic [SAMPLE_BITS-1:0]       sample_echo,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [$clog2(NUM_BUTTONS+REG_EXTRA_COUNT)-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

  `include "resistor_ladder_key_decoder_core_assert.svh"

  localparam int CFG_IDX_BITS = $clog2(NUM_BUTTONS + REG_EXTRA_COUNT);
  localparam logic [CFG_IDX_BITS-1:0] IDX_HALF_WIDTH =
    CFG_IDX_BITS'(NUM_BUTTONS + REG_OFS_HALF_WIDTH);
  localparam logic [CFG_IDX_BITS-1:0] IDX_DEBOUNCE =
    CFG_IDX_BITS'(NUM_BUTTONS + REG_OFS_DEBOUNCE);
  localparam logic [CFG_IDX_BITS-1:0] IDX_HOLD =
    CFG_IDX_BITS'(NUM_BUTTONS + REG_OFS_HOLD);

  logic [SAMPLE_BITS-1:0]     level [NUM_BUTTONS];
  logic [HALF_WIDTH_BITS-1:0] half_width;
  logic [INTERVAL_BITS-1:0]   debounce_ms;
  logic [INTERVAL_BITS-1:0]   hold_repeat_ms;

  logic                   stage_valid;
  logic                   stage_valid_next;
  logic [SAMPLE_BITS-1:0] stage_sample;
  logic [TIME_BITS-1:0]   stage_now;
  logic                   out_valid_next;
  logic                   advance;
  logic                   in_take;
  logic [NUM_BUTTONS-1:0] hit;
  logic [NUM_BUTTONS-1:0] latch_vec;
  btn_status_t            status [NUM_BUTTONS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        level[b] <= '0;
      end
      half_width     <= '0;
      debounce_ms    <= DEBOUNCE_RESET;
      hold_repeat_ms <= HOLD_RESET;
    end else if (cfg_valid) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (cfg_index == CFG_IDX_BITS'(b)) begin
          level[b] <= cfg_data[SAMPLE_BITS-1:0];
        end
      end
      if (cfg_index == IDX_HALF_WIDTH) begin
        half_width <= cfg_data[HALF_WIDTH_BITS-1:0];
      end
      if (cfg_index == IDX_DEBOUNCE) begin
        debounce_ms <= cfg_data[INTERVAL_BITS-1:0];
      end
      if (cfg_index == IDX_HOLD) begin
        hold_repeat_ms <= cfg_data[INTERVAL_BITS-1:0];
      end
    end
  end

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    stage_valid_next = stage_valid;
    if (in_take) begin
      stage_valid_next = 1'b1;
    end else if (advance) begin
      stage_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_sample <= sample;
      stage_now    <= now_ms;
    end
    if (advance) begin
      sample_echo <= stage_sample;
    end
  end

  rlkd_match #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_match (
    .sample    (stage_sample),
    .level     (level),
    .half_width(half_width),
    .hit       (hit)
  );

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    rlkd_button u_button (
      .clk           (clk),
      .rst           (rst),
      .update        (advance),
      .pressed       (hit[b]),
      .now_ms        (stage_now),
      .debounce_ms   (debounce_ms),
      .hold_repeat_ms(hold_repeat_ms),
      .status        (status[b])
    );
    assign click_flags[b]   = status[b].click;
    assign hold_flags[b]    = status[b].hold;
    assign release_flags[b] = status[b].rls;
    assign latch_vec[b]     = status[b].latch;
  end

  `RLKD_ASSERT_IMP(a_flags_exclusive, clk, rst, out_valid,
    ((click_flags & hold_flags) | (click_flags & release_flags) |
     (hold_flags & release_flags)) == '0,
    "button reports more than one flag")
  `RLKD_ASSERT_IMP(a_flags_match_latch, clk, rst, out_valid,
    ((click_flags & ~latch_vec) | (release_flags & latch_vec)) == '0,
    "click or release flag disagrees with press latch")
  `RLKD_ASSERT_NXT(a_stage_drains, clk, rst, stage_valid && !out_valid,
    out_valid, "input stage item did not move to output")
  `RLKD_ASSERT_IMP(a_full_blocks_input, clk, rst,
    stage_valid && out_valid && !out_ready, !in_ready,
    "input accepted while both stages are full and stalled")

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the resistor ladder key decoder: random and directed keypad samples.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlkd_pkg::*;

  localparam int NUM_BTN       = 5;
  localparam int SMP_BITS      = 10;
  localparam int IDX_BITS      = $clog2(NUM_BTN + REG_EXTRA_COUNT);
  localparam int REG_HALF_W    = NUM_BTN + REG_OFS_HALF_WIDTH;
  localparam int REG_DEBOUNCE  = NUM_BTN + REG_OFS_DEBOUNCE;
  localparam int REG_HOLD      = NUM_BTN + REG_OFS_HOLD;
  localparam int REG_COUNT     = NUM_BTN + REG_EXTRA_COUNT;
  localparam int SMP_MAX       = (1 << SMP_BITS) - 1;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_KEYS    = 370;

  typedef struct packed {
    logic [SMP_BITS-1:0]  sample;
    logic [TIME_BITS-1:0] now;
  } key_item_t;

  typedef struct packed {
    logic [NUM_BTN-1:0]  click;
    logic [NUM_BTN-1:0]  hold;
    logic [NUM_BTN-1:0]  rls;
    logic [SMP_BITS-1:0] echo;
  } flag_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SMP_BITS-1:0]      sample = '0;
  logic [TIME_BITS-1:0]     now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [NUM_BTN-1:0]       click_flags;
  logic [NUM_BTN-1:0]       hold_flags;
  logic [NUM_BTN-1:0]       release_flags;
  logic [SMP_BITS-1:0]      sample_echo;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_BITS-1:0]      cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  key_item_t  pending_keys[$];
  flag_word_t expected_flags[$];
  logic       in_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         mismatches = 0;
  int         stall_cycles = 0;
  logic [TIME_BITS-1:0] key_clock = '0;

  logic [SMP_BITS-1:0]      lvl[NUM_BTN];
  logic [HALF_WIDTH_BITS-1:0] half_w;
  logic [INTERVAL_BITS-1:0] debounce;
  logic [INTERVAL_BITS-1:0] hold_rep;
  logic                     latch[NUM_BTN];
  logic [TIME_BITS-1:0]     stamp[NUM_BTN];
  logic                     click_st[NUM_BTN];
  logic                     hold_st[NUM_BTN];
  logic                     rls_st[NUM_BTN];

  logic [CFG_DATA_BITS-1:0] cfg_sets[4][REG_COUNT] = '{
    '{16'd0,   16'd250, 16'd500,  16'd750,  16'd1023, 16'd40,  16'd100,   16'd200},
    '{16'd300, 16'd320, 16'd600,  16'd610,  16'd1000, 16'd50,  16'd20,    16'd50},
    '{16'd0,   16'd511, 16'd1023, 16'd200,  16'd800,  16'd255, 16'd0,     16'd0},
    '{16'd123, 16'd456, 16'd789,  16'd1000, 16'd7,    16'd0,   16'd65535, 16'd65535}
  };

  resistor_ladder_key_decoder_core #(
    .NUM_BUTTONS(NUM_BTN),
    .SAMPLE_BITS(SMP_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .click_flags(click_flags),
    .hold_flags(hold_flags),
    .release_flags(release_flags),
    .sample_echo(sample_echo),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic flag_word_t decode_keys(input logic [SMP_BITS-1:0] smp,
                                             input logic [TIME_BITS-1:0] t);
    int hit;
    logic p;
    flag_word_t r;
    hit = -1;
    for (int b = 0; b < NUM_BTN; b++)
      if (hit < 0 && int'(smp) >= int'(lvl[b]) - int'(half_w)
          && int'(smp) <= int'(lvl[b]) + int'(half_w))
        hit = b;
    for (int b = 0; b < NUM_BTN; b++) begin
      p = (b == hit);
      if (p && !latch[b] && t - stamp[b] > debounce) begin
        latch[b] = 1'b1;
        stamp[b] = t;
        {click_st[b], hold_st[b], rls_st[b]} = 3'b100;
      end
      if (p && latch[b] && t - stamp[b] > hold_rep) begin
        stamp[b] = t;
        {click_st[b], hold_st[b], rls_st[b]} = 3'b010;
      end
      if (!p && !latch[b])
        {click_st[b], hold_st[b], rls_st[b]} = 3'b000;
      if (!p && latch[b] && t - stamp[b] > debounce) begin
        latch[b] = 1'b0;
        stamp[b] = t;
        {click_st[b], hold_st[b], rls_st[b]} = 3'b001;
      end
      r.click[b] = click_st[b];
      r.hold[b]  = hold_st[b];
      r.rls[b]   = rls_st[b];
    end
    r.echo = smp;
    return r;
  endfunction

  function automatic void apply_reg(input int idx, input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_HALF_W:   half_w = data[HALF_WIDTH_BITS-1:0];
      REG_DEBOUNCE: debounce = data[INTERVAL_BITS-1:0];
      REG_HOLD:     hold_rep = data[INTERVAL_BITS-1:0];
      default: begin
        if (idx < NUM_BTN) lvl[idx] = data[SMP_BITS-1:0];
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t %s: expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  function automatic void push_key(input int smp, input logic [TIME_BITS-1:0] t);
    key_item_t it;
    it.sample = smp[SMP_BITS-1:0];
    it.now    = t;
    pending_keys.push_back(it);
  endfunction

  // Mostly runs of one button (or none) with advancing time; some noise that jumps the clock.
  task automatic gen_keys(input int n);
    int btn, run, off, v, sel;
    int unsigned span, step;
    span = ((hold_rep > debounce) ? hold_rep : debounce) + 1;
    while (n > 0) begin
      if ($urandom_range(99) < 15) begin
        key_clock = $urandom();
        push_key($urandom_range(SMP_MAX), key_clock);
        n--;
      end else begin
        btn = $urandom_range(NUM_BTN);
        run = $urandom_range(2, 12);
        for (int k = 0; k < run && n > 0; k++) begin
          if (btn == NUM_BTN) begin
            v = $urandom_range(SMP_MAX);
          end else begin
            off = int'($urandom_range(2 * half_w)) - int'(half_w);
            v = int'(lvl[btn]) + off;
            if (v < 0) v = 0;
            if (v > SMP_MAX) v = SMP_MAX;
          end
          sel = $urandom_range(99);
          if (sel < 60) step = $urandom_range(0, span / 2);
          else if (sel < 95) step = $urandom_range(span / 2, 2 * span);
          else step = $urandom_range(0, 4 * span);
          key_clock = key_clock + step;
          push_key(v, key_clock);
          n--;
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_keys.size() != 0 || in_valid || expected_flags.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_regs(input int set_no);
    logic [CFG_DATA_BITS-1:0] data;
    for (int i = 0; i < REG_COUNT; i++) begin
      data = cfg_sets[set_no][i];
      if (i < NUM_BTN) data = data | CFG_DATA_BITS'($urandom_range(63) << SMP_BITS);
      else if (i == REG_HALF_W)
        data = data | CFG_DATA_BITS'($urandom_range(255) << HALF_WIDTH_BITS);
      cfg_valid <= 1'b1;
      cfg_index <= IDX_BITS'(i);
      cfg_data  <= data;
      do @(posedge clk); while (!cfg_ready);
      apply_reg(i, data);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          sample   <= pending_keys[0].sample;
          now_ms   <= pending_keys[0].now;
          pending_keys.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    flag_word_t want, got;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) expected_flags.push_back(decode_keys(sample, now_ms));
      if (out_valid && out_ready) begin
        got = {click_flags, hold_flags, release_flags, sample_echo};
        if (expected_flags.size() == 0) begin
          $display("%0t unexpected item: expected none, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = expected_flags.pop_front();
          check_field("click_flags", 32'(want.click), 32'(got.click));
          check_field("hold_flags", 32'(want.hold), 32'(got.hold));
          check_field("release_flags", 32'(want.rls), 32'(got.rls));
          check_field("sample_echo", 32'(want.echo), 32'(got.echo));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [TIME_BITS-1:0] t0;
    for (int b = 0; b < NUM_BTN; b++) begin
      lvl[b] = '0;
      latch[b] = 1'b0;
      stamp[b] = '0;
      click_st[b] = 1'b0;
      hold_st[b] = 1'b0;
      rls_st[b] = 1'b0;
    end
    half_w   = '0;
    debounce = DEBOUNCE_RESET;
    hold_rep = HOLD_RESET;
    send_idle_pct = 19;
    recv_idle_pct = 72;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset values: every level at zero with no window, so only a zero sample hits
    push_key(0, 0);
    push_key(0, 101);
    push_key(0, 302);
    push_key(0, 450);
    push_key(5, 560);
    push_key(SMP_MAX, 600);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 19 : 0;
      write_regs(ph);
      if (ph == 0) begin
        // window edges at both ends of the range, click/hold/release across the time wrap
        t0 = 32'hFFFF_FF80;
        push_key(0, t0);
        push_key(40, t0 + 32'd150);
        push_key(40, t0 + 32'd260);
        push_key(41, t0 + 32'd300);
        push_key(SMP_MAX, t0 + 32'd420);
        push_key(983, t0 + 32'd430);
        push_key(982, t0 + 32'd440);
        push_key(210, t0 + 32'd600);
        push_key(290, t0 + 32'd610);
        push_key(291, t0 + 32'd615);
        push_key(500, t0 + 32'd900);
        push_key(750, t0 + 32'd1200);
        key_clock = t0 + 32'd1300;
      end else begin
        key_clock = $urandom();
      end
      gen_keys(PHASE_KEYS);
      wait_drained();
    end

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
